[sv/pcpd_pkg.sv]
// shared constants, types and helpers for the per-class priority deque
`default_nettype none
package pcpd_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int NUM_QUEUES  = 16;

  localparam int NUM_ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_POP = 1'b1;

  localparam logic [1:0] CODE_ADDED  = 2'd0;
  localparam logic [1:0] CODE_FULL   = 2'd1;
  localparam logic [1:0] CODE_SERVED = 2'd2;
  localparam logic [1:0] CODE_EMPTY  = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic        urg;
  } entry_t;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wdata;
  } ram_req_t;

  function automatic logic [AW-1:0] addr_of(logic [QW-1:0] q, logic [SW-1:0] s);
    logic [AW:0] a;
    a = (AW+1)'(q) * (AW+1)'(QUEUE_DEPTH) + (AW+1)'(s);
    return a[AW-1:0];
  endfunction

  function automatic logic [3:0] len_field(logic [LW-1:0] l);
    logic [LW+3:0] t;
    t = {4'b0000, l};
    return t[3:0];
  endfunction

endpackage
`default_nettype wire

[sv/pcpd_if.sv]
// request and response channel interfaces
`default_nettype none
interface pcpd_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  queue_index;
  logic [15:0] entry_id;
  logic        urgent;

  modport source (output valid, mode, queue_index, entry_id, urgent, input ready);
  modport sink   (input valid, mode, queue_index, entry_id, urgent, output ready);
endinterface

interface pcpd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_code;
  logic [15:0] served_id;
  logic        served_urgent;
  logic [3:0]  queue_length;

  modport source (output valid, result_code, served_id, served_urgent, queue_length,
                  input ready);
  modport sink   (input valid, result_code, served_id, served_urgent, queue_length,
                  output ready);
endinterface
`default_nettype wire

[sv/pcpd_entry_ram.sv]
// entry store: one write port, one registered read port
`default_nettype none
module pcpd_entry_ram
  import pcpd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire ram_req_t req_i,
  output entry_t        rdata_o
);

  entry_t mem [NUM_ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[sv/per_class_priority_deque_core.sv]
// per-class priority deque: sequencer, queue lengths and response register
//
//  channel | dir | payload                                              | handshake
//  req_if  | in  | mode, queue_index, entry_id, urgent                  | valid/ready
//  rsp_if  | out | result_code, served_id, served_urgent, queue_length  | valid/ready
//
// a rejected add, an empty pop or a bad index goes straight to the response; a tail
// add or an urgent add to an empty queue writes its entry at once; any other urgent
// add or a pop first shifts the queue, the entries moving one per cycle through the
// single port pair of the entry ram. a held result waits in the response state.
// reset clears queue lengths, state, count and flags; entries stay undefined.
// ready is high whenever the sequencer is idle, even while a result waits on rsp_if.
`default_nettype none
module per_class_priority_deque_core
  import pcpd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pcpd_req_if.sink    req_if,
  pcpd_rsp_if.source  rsp_if
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_HEAD  = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic          mode_q, mode_d;
  logic [QW-1:0] q_q, q_d;
  logic [15:0]   id_q, id_d;
  logic          urg_q, urg_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] src_q, src_d;
  logic [SW-1:0] dst_q, dst_d;
  logic [SW-1:0] wslot_q, wslot_d;
  logic          rd_v_q, rd_v_d;
  logic          cap_q, cap_d;

  logic [1:0]    res_code_q, res_code_d;
  logic [15:0]   res_id_q, res_id_d;
  logic          res_urg_q, res_urg_d;
  logic [3:0]    res_len_q, res_len_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_code_q;
  logic [15:0]   out_id_q;
  logic          out_urg_q;
  logic [3:0]    out_len_q;
  logic          out_load;

  logic [LW-1:0] lengths_q [NUM_QUEUES];
  logic          len_we;
  logic [LW-1:0] len_new;

  logic          acc;
  logic [QW-1:0] in_q;
  logic          in_q_ok;
  logic [LW-1:0] in_len;

  ram_req_t      ram_req;
  entry_t        rdata;

  pcpd_entry_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  assign req_if.ready = (state_q == ST_IDLE);
  assign acc          = req_if.valid && req_if.ready;
  assign in_q         = QW'(req_if.queue_index);
  assign in_q_ok      = (32'(req_if.queue_index) < 32'(NUM_QUEUES));
  assign in_len       = lengths_q[in_q];

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    q_d        = q_q;
    id_d       = id_q;
    urg_d      = urg_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    src_d      = src_q;
    dst_d      = dst_q;
    wslot_d    = wslot_q;
    rd_v_d     = 1'b0;
    cap_d      = cap_q;
    res_code_d = res_code_q;
    res_id_d   = res_id_q;
    res_urg_d  = res_urg_q;
    res_len_d  = res_len_q;
    len_we     = 1'b0;
    len_new    = in_len;
    out_load   = 1'b0;

    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = addr_of(q_q, src_q);
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = addr_of(q_q, dst_q);
    ram_req.wdata   = rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          mode_d    = req_if.mode;
          q_d       = in_q;
          id_d      = req_if.entry_id;
          urg_d     = req_if.urgent;
          len_d     = in_len;
          res_id_d  = 16'd0;
          res_urg_d = 1'b0;
          if (!in_q_ok) begin
            res_code_d = (req_if.mode == MODE_POP) ? CODE_EMPTY : CODE_FULL;
            res_len_d  = 4'd0;
            state_d    = ST_RESP;
          end else if (req_if.mode == MODE_ADD) begin
            if (in_len >= LW'(QUEUE_DEPTH)) begin
              res_code_d = CODE_FULL;
              res_len_d  = len_field(in_len);
              state_d    = ST_RESP;
            end else begin
              len_we     = 1'b1;
              len_new    = in_len + LW'(1);
              res_code_d = CODE_ADDED;
              res_len_d  = len_field(len_new);
              if (req_if.urgent && (in_len != '0)) begin
                src_d   = SW'(in_len - LW'(1));
                cnt_d   = in_len;
                wslot_d = '0;
                state_d = ST_SHIFT;
              end else begin
                wslot_d = req_if.urgent ? '0 : SW'(in_len);
                state_d = ST_HEAD;
              end
            end
          end else begin
            if (in_len == '0) begin
              res_code_d = CODE_EMPTY;
              res_len_d  = 4'd0;
              state_d    = ST_RESP;
            end else begin
              len_we     = 1'b1;
              len_new    = in_len - LW'(1);
              res_code_d = CODE_SERVED;
              res_len_d  = len_field(len_new);
              src_d      = '0;
              cnt_d      = in_len;
              state_d    = ST_SHIFT;
            end
          end
        end
      end
      ST_SHIFT: begin
        // data read last cycle lands here: captured if it is the head on a pop, else moved
        if (rd_v_q) begin
          if (cap_q) begin
            res_id_d  = rdata.id;
            res_urg_d = rdata.urg;
          end else begin
            ram_req.wr_en = 1'b1;
          end
        end
        if (cnt_q != '0) begin
          ram_req.rd_en = 1'b1;
          rd_v_d        = 1'b1;
          cnt_d         = cnt_q - LW'(1);
          if (mode_q == MODE_POP) begin
            cap_d = (src_q == '0);
            dst_d = src_q - SW'(1);
            src_d = src_q + SW'(1);
          end else begin
            cap_d = 1'b0;
            dst_d = src_q + SW'(1);
            src_d = src_q - SW'(1);
          end
        end else begin
          state_d = (mode_q == MODE_POP) ? ST_RESP : ST_HEAD;
        end
      end
      ST_HEAD: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = addr_of(q_q, wslot_q);
        ram_req.wdata   = '{id: id_q, urg: urg_q};
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || rsp_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && !rsp_if.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_v_q      <= 1'b0;
      cap_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        lengths_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rd_v_q      <= rd_v_d;
      cap_q       <= cap_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (len_we) begin
        lengths_q[in_q] <= len_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    q_q        <= q_d;
    id_q       <= id_d;
    urg_q      <= urg_d;
    len_q      <= len_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    wslot_q    <= wslot_d;
    res_code_q <= res_code_d;
    res_id_q   <= res_id_d;
    res_urg_q  <= res_urg_d;
    res_len_q  <= res_len_d;
    if (out_load) begin
      out_code_q <= res_code_q;
      out_id_q   <= res_id_q;
      out_urg_q  <= res_urg_q;
      out_len_q  <= res_len_q;
    end
  end

  assign rsp_if.valid         = out_valid_q;
  assign rsp_if.result_code   = out_code_q;
  assign rsp_if.served_id     = out_id_q;
  assign rsp_if.served_urgent = out_urg_q;
  assign rsp_if.queue_length  = out_len_q;

`ifndef SYNTHESIS
  a_rdata_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> $past(ram_req.rd_en))
    else $error("read data flagged without a read in the previous cycle");

  a_shift_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (cnt_q <= len_q))
    else $error("shift count beyond queue length");

  a_move_within_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && ram_req.wr_en) |-> (32'(dst_q) <= 32'(len_q)))
    else $error("entry move outside the occupied slots");

  a_head_write_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEAD) |-> (mode_q == MODE_ADD && res_code_q == CODE_ADDED))
    else $error("entry write on a request that adds nothing");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
// testbench for the per-class priority deque: directed table, random traffic, in-order checking
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import pcpd_pkg::*;
();

  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_TAIL    = 80;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic        mode;
    logic [3:0]  qi;
    logic [15:0] id;
    logic        urg;
  } deque_req_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [15:0] sid;
    logic        surg;
    logic [3:0]  len;
  } deque_rsp_t;

  typedef struct {
    deque_req_t req;
    bit         typed;
    deque_rsp_t rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcpd_req_if req ();
  pcpd_rsp_if rsp ();

  per_class_priority_deque_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req),
    .rsp_if (rsp)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the queue bank
  entry_t slots [NUM_QUEUES][QUEUE_DEPTH];
  int     occupancy [NUM_QUEUES];

  deque_rsp_t expected_results [$];
  stim_row_t  stim_rows [$];

  int  mismatches;
  int  cycles;
  bit  calm;
  int  n_added, n_full, n_served, n_empty, n_urgent_added, deepest;

  function automatic deque_rsp_t deque_apply(deque_req_t r);
    deque_rsp_t res;
    int n;
    res = '0;
    if (r.qi >= NUM_QUEUES) begin
      res.code = (r.mode == MODE_POP) ? CODE_EMPTY : CODE_FULL;
      return res;
    end
    n = occupancy[r.qi];
    if (r.mode == MODE_ADD) begin
      if (n >= QUEUE_DEPTH) begin
        res.code = CODE_FULL;
        res.len  = 4'(n);
      end else begin
        if (r.urg) begin
          for (int i = n; i > 0; i--) slots[r.qi][i] = slots[r.qi][i-1];
          slots[r.qi][0] = '{id: r.id, urg: 1'b1};
        end else begin
          slots[r.qi][n] = '{id: r.id, urg: 1'b0};
        end
        occupancy[r.qi] = n + 1;
        res.code = CODE_ADDED;
        res.len  = 4'(n + 1);
      end
    end else if (n == 0) begin
      res.code = CODE_EMPTY;
    end else begin
      res.code = CODE_SERVED;
      res.sid  = slots[r.qi][0].id;
      res.surg = slots[r.qi][0].urg;
      for (int i = 1; i < n; i++) slots[r.qi][i-1] = slots[r.qi][i];
      occupancy[r.qi] = n - 1;
      res.len = 4'(n - 1);
    end
    return res;
  endfunction

  function automatic void report_mismatch(string what, deque_rsp_t e, deque_rsp_t g);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("tb: %s at cycle %0d: expected %0d/%h/%b/%0d, got %0d/%h/%b/%0d",
               what, cycles, e.code, e.sid, e.surg, e.len, g.code, g.sid, g.surg, g.len);
  endfunction

  task automatic add_row(logic mode, logic [3:0] qi, logic [15:0] id, logic urg,
                         bit typed = 1'b0, logic [1:0] code = CODE_ADDED,
                         logic [15:0] sid = '0, logic surg = 1'b0, logic [3:0] len = '0);
    stim_row_t row;
    row.req   = '{mode: mode, qi: qi, id: id, urg: urg};
    row.typed = typed;
    row.rsp   = '{code: code, sid: sid, surg: surg, len: len};
    stim_rows.push_back(row);
  endtask

  task automatic idle_req(int n);
    repeat (n) begin
      @(negedge clk_i);
      req.valid <= 1'b0;
    end
  endtask

  // drive one item, wait for it to be taken, then record what it should produce
  task automatic send_req(deque_req_t r, bit typed, deque_rsp_t typed_rsp);
    deque_rsp_t predicted;
    @(negedge clk_i);
    req.valid       <= 1'b1;
    req.mode        <= r.mode;
    req.queue_index <= r.qi;
    req.entry_id    <= r.id;
    req.urgent      <= r.urg;
    do @(posedge clk_i); while (!req.ready);
    predicted = deque_apply(r);
    expected_results.push_back(typed ? typed_rsp : predicted);
    case (predicted.code)
      CODE_ADDED: begin
        n_added++;
        if (r.urg) n_urgent_added++;
      end
      CODE_FULL:   n_full++;
      CODE_SERVED: n_served++;
      default:     n_empty++;
    endcase
    if (occupancy[r.qi] > deepest) deepest = occupancy[r.qi];
  endtask

  // response side back-pressure in short bursts
  int stall_left;
  always @(negedge clk_i) begin
    if (calm) begin
      stall_left = 0;
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    deque_rsp_t got;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{code: rsp.result_code, sid: rsp.served_id, surg: rsp.served_urgent,
              len: rsp.queue_length};
      if (expected_results.size() == 0)
        report_mismatch("unexpected item", 'x, got);
      else if (got !== expected_results[0])
        report_mismatch("mismatch", expected_results.pop_front(), got);
      else
        void'(expected_results.pop_front());
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: timeout with %0d items outstanding", expected_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    deque_rsp_t none;
    deque_req_t r;
    int add_pct;
    none = '0;
    rst_ni          = 1'b0;
    req.valid       = 1'b0;
    req.mode        = MODE_ADD;
    req.queue_index = '0;
    req.entry_id    = '0;
    req.urgent      = 1'b0;
    rsp.ready       = 1'b0;
    calm            = 1'b0;
    stall_left      = 0;
    cycles          = 0;
    mismatches      = 0;
    for (int q = 0; q < NUM_QUEUES; q++) occupancy[q] = 0;

    // empty pop with junk in the ignored fields
    add_row(MODE_POP, 4'd0,  16'hA5A5, 1'b1, 1'b1, CODE_EMPTY);
    add_row(MODE_ADD, 4'd15, 16'hFFFF, 1'b0, 1'b1, CODE_ADDED, '0, 1'b0, 4'd1);
    add_row(MODE_ADD, 4'd15, 16'h0000, 1'b1, 1'b1, CODE_ADDED, '0, 1'b0, 4'd2);
    add_row(MODE_POP, 4'd15, 16'h0000, 1'b0);
    add_row(MODE_POP, 4'd15, 16'hFFFF, 1'b1);
    add_row(MODE_POP, 4'd15, 16'h0000, 1'b0, 1'b1, CODE_EMPTY);
    // fill one class with a mix of urgent and regular entries
    for (int k = 1; k <= QUEUE_DEPTH; k++)
      add_row(MODE_ADD, 4'd3, 16'(k * 16'h1111), logic'(k % 2));
    add_row(MODE_ADD, 4'd3, 16'h5A5A, 1'b0, 1'b1, CODE_FULL, '0, 1'b0, 4'(QUEUE_DEPTH));
    add_row(MODE_ADD, 4'd3, 16'hC3C3, 1'b1, 1'b1, CODE_FULL, '0, 1'b0, 4'(QUEUE_DEPTH));
    for (int k = 0; k < QUEUE_DEPTH; k++)
      add_row(MODE_POP, 4'd3, 16'(k), 1'b0);
    add_row(MODE_POP, 4'd3, 16'h0000, 1'b0, 1'b1, CODE_EMPTY);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if ($urandom_range(0, 3) == 0) idle_req($urandom_range(1, 4));
      send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
    end

    // random traffic: fill-heavy and drain-heavy spells, mostly on a few classes
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= RANDOM_ITEMS - CALM_TAIL) || ((k / 60) % 4 == 3);
      add_pct = ((k / 100) % 2 == 0) ? 75 : 30;
      r.mode = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_POP;
      r.qi   = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                          : 4'($urandom_range(0, NUM_QUEUES - 1));
      r.id   = 16'($urandom);
      r.urg  = 1'($urandom_range(0, 1));
      if (!calm && $urandom_range(0, 3) == 0) idle_req($urandom_range(1, 4));
      send_req(r, 1'b0, none);
    end
    @(negedge clk_i);
    req.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d items: %0d added (%0d urgent), %0d full, %0d served, %0d empty",
             stim_rows.size() + RANDOM_ITEMS, n_added, n_urgent_added, n_full, n_served,
             n_empty);
    $display("tb: deepest class held %0d entries, %0d mismatches", deepest, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

[per_class_priority_deque_core.f]
sv/pcpd_pkg.sv
sv/pcpd_if.sv
sv/pcpd_entry_ram.sv
sv/per_class_priority_deque_core.sv
bench/tb_top.sv
